// File: rtl/aimed_pkg.sv
// shared constants and types of the ascii integer median-of-three block
`default_nettype none

package aimed_pkg;

  // default signed width of one entered value
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // depth of the history window
  localparam int unsigned WINDOW_DEPTH = 3;

  // character codes
  localparam logic [7:0] CH_END   = 8'h65;  // 'e'
  localparam logic [7:0] CH_CLEAR = 8'h46;  // 'F'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // window fill codes
  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_ONE   = 2'd1;
  localparam logic [1:0] HELD_TWO   = 2'd2;
  localparam logic [1:0] HELD_THREE = 2'd3;

  // decoded window commands from the entry parser
  typedef struct packed {
    logic push;   // number complete, push into window
    logic clear;  // empty the window
  } aimed_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/aimed_char_if.sv
// input channel: one ascii character per word
`default_nettype none

interface aimed_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// File: rtl/aimed_res_if.sv
// result channel: entered value, window sum, median and fill count
`default_nettype none

interface aimed_res_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] entered_value;
  logic signed [VALUE_WIDTH+1:0] window_sum;
  logic signed [VALUE_WIDTH-1:0] window_median;
  logic [1:0]                    values_held;

  modport source (output valid, output entered_value, output window_sum,
                  output window_median, output values_held, input ready);
  modport sink   (input valid, input entered_value, input window_sum,
                  input window_median, input values_held, output ready);
endinterface

`default_nettype wire

// File: rtl/aimed_entry.sv
// number entry parser: digits, sign and saturating accumulator
`default_nettype none

module aimed_entry #(
  parameter int unsigned VALUE_WIDTH = aimed_pkg::VALUE_WIDTH_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire  [7:0]                    char_i,
  input  wire                           fire_i,
  output aimed_pkg::aimed_ctrl_t        ctrl_o,
  output logic signed [VALUE_WIDTH-1:0] value_o
);
  import aimed_pkg::*;

  localparam int unsigned ProdWidth = VALUE_WIDTH + 4;
  localparam logic [ProdWidth-1:0] Limit = ProdWidth'(1) << (VALUE_WIDTH - 1);
  localparam logic [VALUE_WIDTH-1:0] MaxPos = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic                   empty_q, empty_d;
  logic                   is_digit;
  logic [ProdWidth-1:0]   next_acc;

  // character decode
  assign is_digit      = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign ctrl_o.push   = (char_i == CH_END);
  assign ctrl_o.clear  = (char_i == CH_CLEAR);

  // acc * 10 + digit, digit is the low nibble of the code
  assign next_acc = ProdWidth'({acc_q, 3'b000}) + ProdWidth'({acc_q, 1'b0})
                  + ProdWidth'(char_i[3:0]);

  // finished value; magnitude never exceeds the limit
  always_comb begin
    if (neg_q) begin
      value_o = VALUE_WIDTH'(0) - acc_q;
    end else if (acc_q[VALUE_WIDTH-1]) begin
      value_o = MaxPos;
    end else begin
      value_o = acc_q;
    end
  end

  // entry state update
  always_comb begin
    acc_d   = acc_q;
    neg_d   = neg_q;
    empty_d = empty_q;
    if (fire_i) begin
      if (ctrl_o.push) begin
        acc_d   = '0;
        neg_d   = 1'b0;
        empty_d = 1'b1;
      end else if (is_digit) begin
        if (acc_q[VALUE_WIDTH-1] || (next_acc > Limit)) begin
          acc_d = Limit[VALUE_WIDTH-1:0];
        end else begin
          acc_d = next_acc[VALUE_WIDTH-1:0];
        end
        empty_d = 1'b0;
      end else if ((char_i == CH_MINUS) && empty_q) begin
        neg_d   = 1'b1;
        empty_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      neg_q   <= 1'b0;
      empty_q <= 1'b1;
    end else begin
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      empty_q <= empty_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/aimed_window.sv
// three-deep history window with sum, median and result register
`default_nettype none

module aimed_window #(
  parameter int unsigned VALUE_WIDTH = aimed_pkg::VALUE_WIDTH_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           fire_i,
  input  wire aimed_pkg::aimed_ctrl_t   ctrl_i,
  input  wire  signed [VALUE_WIDTH-1:0] value_i,
  output logic                          slot_free_o,
  aimed_res_if.source                   res_o
);
  import aimed_pkg::*;

  localparam int unsigned SumWidth = VALUE_WIDTH + 2;

  logic signed [VALUE_WIDTH-1:0] win_q [WINDOW_DEPTH];
  logic signed [VALUE_WIDTH-1:0] win_d [WINDOW_DEPTH];
  logic [1:0]                    cnt_q, cnt_d;

  logic                          res_valid_q, res_valid_d;
  logic signed [VALUE_WIDTH-1:0] res_value_q;
  logic signed [SumWidth-1:0]    res_sum_q, sum_d;
  logic signed [VALUE_WIDTH-1:0] res_median_q, median_d;
  logic [1:0]                    res_held_q;

  logic                          do_push;
  logic signed [VALUE_WIDTH:0]   pair_sum, pair_adj;
  logic signed [VALUE_WIDTH-1:0] lo01, hi01, hi_c;

  assign do_push     = fire_i && ctrl_i.push;
  assign slot_free_o = !res_valid_q || res_o.ready;

  // window shift, fill or clear
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      win_d[i] = win_q[i];
    end
    cnt_d = cnt_q;
    if (do_push) begin
      case (cnt_q)
        HELD_NONE: begin
          win_d[0] = value_i;
          cnt_d    = HELD_ONE;
        end
        HELD_ONE: begin
          win_d[1] = value_i;
          cnt_d    = HELD_TWO;
        end
        HELD_TWO: begin
          win_d[2] = value_i;
          cnt_d    = HELD_THREE;
        end
        default: begin
          win_d[0] = win_q[1];
          win_d[1] = win_q[2];
          win_d[2] = value_i;
        end
      endcase
    end else if (fire_i && ctrl_i.clear) begin
      cnt_d = HELD_NONE;
    end
  end

  // sum of held values, stale slots masked
  always_comb begin
    sum_d = SumWidth'(win_d[0]);
    if (cnt_d != HELD_ONE) begin
      sum_d = sum_d + SumWidth'(win_d[1]);
    end
    if (cnt_d == HELD_THREE) begin
      sum_d = sum_d + SumWidth'(win_d[2]);
    end
  end

  // mean of two, rounded toward zero
  assign pair_sum = (VALUE_WIDTH+1)'(win_d[0]) + (VALUE_WIDTH+1)'(win_d[1]);
  assign pair_adj = pair_sum + (VALUE_WIDTH+1)'(pair_sum[VALUE_WIDTH]);

  // middle of three
  assign lo01 = (win_d[0] < win_d[1]) ? win_d[0] : win_d[1];
  assign hi01 = (win_d[0] < win_d[1]) ? win_d[1] : win_d[0];
  assign hi_c = (hi01 < win_d[2]) ? hi01 : win_d[2];

  always_comb begin
    case (cnt_d)
      HELD_ONE:   median_d = win_d[0];
      HELD_TWO:   median_d = pair_adj[VALUE_WIDTH:1];
      default:    median_d = (lo01 > hi_c) ? lo01 : hi_c;
    endcase
  end

  // result handshake
  always_comb begin
    res_valid_d = res_valid_q;
    if (do_push) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= HELD_NONE;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // window storage and result payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      win_q[i] <= win_d[i];
    end
    if (do_push) begin
      res_value_q  <= value_i;
      res_sum_q    <= sum_d;
      res_median_q <= median_d;
      res_held_q   <= cnt_d;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.entered_value = res_value_q;
  assign res_o.window_sum    = res_sum_q;
  assign res_o.window_median = res_median_q;
  assign res_o.values_held   = res_held_q;

endmodule

`default_nettype wire

// File: rtl/ascii_integer_median_of_three_top.sv
// top level: ascii integer entry with running median-of-three window
//
//  channel  | dir | word contents
//  ---------+-----+---------------------------------------------------------
//  char_i   | in  | char_code[7:0]
//  res_o    | out | entered_value, window_sum, window_median, values_held
//
// one character per cycle while no 'e' stalls: each word is held in the input register,
// then parser and window logic update state and load the result register.
// an accepted 'e' reaches its result word through the input register and the result register.
// reset clears accumulator, sign, window count and both valid flags.
// only an 'e' waits on a full result register; other characters never stall.
`default_nettype none

module ascii_integer_median_of_three_top #(
  parameter int unsigned VALUE_WIDTH = aimed_pkg::VALUE_WIDTH_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  aimed_char_if.sink   char_i,
  aimed_res_if.source  res_o
);
  import aimed_pkg::*;

  logic                          in_valid_q, in_valid_d;
  logic [7:0]                    char_q;
  logic                          fire;
  logic                          slot_free;
  aimed_ctrl_t                   ctrl;
  logic signed [VALUE_WIDTH-1:0] value;

  // the held word moves on unless it is an 'e' facing a full result slot
  assign fire         = in_valid_q && (!ctrl.push || slot_free);
  assign char_i.ready = !in_valid_q || fire;

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (char_i.ready) begin
      in_valid_d = char_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      char_q <= char_i.char_code;
    end
  end

  aimed_entry #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_entry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_q),
    .fire_i  (fire),
    .ctrl_o  (ctrl),
    .value_o (value)
  );

  aimed_window #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .ctrl_i      (ctrl),
    .value_i     (value),
    .slot_free_o (slot_free),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// File: sim/ascii_integer_median_of_three_top_tb.sv
`timescale 1ns / 100ps
// testbench of the ascii integer median-of-three block: random character streams, checked results

module ascii_integer_median_of_three_top_tb;
  import aimed_pkg::*;

  localparam int unsigned VALUE_W     = VALUE_WIDTH_DEF;
  localparam int          CHAR_TARGET = 1950;
  localparam int          CYCLE_LIMIT = 500000;

  // one expected result word
  typedef struct {
    logic signed [VALUE_W-1:0] entered;
    logic signed [VALUE_W+1:0] sum;
    logic signed [VALUE_W-1:0] median;
    logic [1:0]                held;
  } window_result_t;

  // tracks entry and window state, predicts and checks result words
  class median_window_tracker;
    longint unsigned magnitude;
    bit              negative;
    bit              fresh;
    longint          slots[WINDOW_DEPTH];
    logic [1:0]      held;
    window_result_t  pending_windows[$];
    int              errors;

    function new();
      magnitude = 0;
      negative  = 1'b0;
      fresh     = 1'b1;
      held      = HELD_NONE;
      errors    = 0;
      foreach (slots[i]) slots[i] = 0;
    endfunction

    // update state for one accepted character, queue a result on 'e'
    function void note_char(logic [7:0] c);
      longint unsigned lim;
      longint unsigned nxt;
      longint          val;
      longint          total;
      longint          mid;
      longint          lo;
      longint          hi;
      window_result_t  r;
      lim = 64'd1 << (VALUE_W - 1);
      if (c == CH_END) begin
        // saturate the magnitude at the signed limits
        if (negative) begin
          val = (magnitude >= lim) ? -longint'(lim) : -longint'(magnitude);
        end else begin
          val = (magnitude >= lim) ? longint'(lim - 1) : longint'(magnitude);
        end
        magnitude = 0;
        negative  = 1'b0;
        fresh     = 1'b1;
        // push, dropping the oldest once full
        if (held != HELD_THREE) begin
          slots[held] = val;
          held++;
        end else begin
          slots[0] = slots[1];
          slots[1] = slots[2];
          slots[2] = val;
        end
        total = 0;
        for (int i = 0; i < held; i++) total += slots[i];
        case (held)
          HELD_ONE: begin
            mid = slots[0];
          end
          HELD_TWO: begin
            mid = (slots[0] + slots[1]) / 2;
          end
          default: begin
            lo  = (slots[0] < slots[1]) ? slots[0] : slots[1];
            hi  = (slots[0] < slots[1]) ? slots[1] : slots[0];
            hi  = (hi < slots[2]) ? hi : slots[2];
            mid = (lo > hi) ? lo : hi;
          end
        endcase
        r.entered = val[VALUE_W-1:0];
        r.sum     = total[VALUE_W+1:0];
        r.median  = mid[VALUE_W-1:0];
        r.held    = held;
        pending_windows.push_back(r);
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        nxt = magnitude * 10 + longint'(c - CH_ZERO);
        if (magnitude >= lim || nxt > lim) nxt = lim;
        magnitude = nxt;
        fresh     = 1'b0;
      end else if (c == CH_MINUS && fresh) begin
        negative = 1'b1;
        fresh    = 1'b0;
      end else if (c == CH_CLEAR) begin
        held = HELD_NONE;
      end
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_result(logic signed [VALUE_W-1:0] entered,
                               logic signed [VALUE_W+1:0] sum,
                               logic signed [VALUE_W-1:0] median,
                               logic [1:0] held_now);
      window_result_t x;
      if (pending_windows.size() == 0) begin
        $display("%0t: unexpected result word, entered_value %0d", $time, entered);
        errors++;
        return;
      end
      x = pending_windows.pop_front();
      if (entered !== x.entered) begin
        $display("%0t: entered_value expected %0d got %0d", $time, x.entered, entered);
        errors++;
      end
      if (sum !== x.sum) begin
        $display("%0t: window_sum expected %0d got %0d", $time, x.sum, sum);
        errors++;
      end
      if (median !== x.median) begin
        $display("%0t: window_median expected %0d got %0d", $time, x.median, median);
        errors++;
      end
      if (held_now !== x.held) begin
        $display("%0t: values_held expected %0d got %0d", $time, x.held, held_now);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cycles;
  int   chars_taken;
  bit   sender_calm;

  median_window_tracker tracker = new();

  aimed_char_if                      char_if ();
  aimed_res_if #(.VALUE_WIDTH(VALUE_W)) res_if ();

  ascii_integer_median_of_three_top #(
    .VALUE_WIDTH(VALUE_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .char_i(char_if),
    .res_o (res_if)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // idle length: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit is_command(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS || c == CH_END || c == CH_CLEAR;
  endfunction

  // any character the block ignores
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_command(c));
    return c;
  endfunction

  // offer one word and wait for it to be taken
  task automatic send_char(input logic [7:0] c);
    int gap;
    if ($urandom_range(0, 99) < 2) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : gap_len();
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= c;
    do @(posedge clk_i); while (!char_if.ready);
    tracker.note_char(c);
    if (is_command(c)) chars_taken++;
  endtask

  // decimal digits of a magnitude, with optional sign, then end
  task automatic send_number(input longint unsigned mag, input bit neg);
    string s;
    s = $sformatf("%0d", mag);
    if (neg) send_char(CH_MINUS);
    foreach (s[i]) send_char(s[i]);
    send_char(CH_END);
  endtask

  // one random entry, mostly well formed
  task automatic send_entry();
    logic [7:0] seq[$];
    string      s;
    int         kind;
    int         ndig;
    kind = $urandom_range(0, 19);
    if (kind >= 1 && kind < 4) begin
      // right around the saturation point
      s = $sformatf("%0d", 64'd2147483646 + $urandom_range(0, 3));
      foreach (s[i]) seq.push_back(s[i]);
    end else if (kind >= 4) begin
      ndig = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      repeat (ndig) seq.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 4) == 0) seq.push_front(CH_ZERO);
    // late minus, after the first digit
    if (seq.size() > 0 && $urandom_range(0, 9) == 0) begin
      seq.insert($urandom_range(1, seq.size()), CH_MINUS);
    end
    if ($urandom_range(0, 1) == 1) seq.push_front(CH_MINUS);
    if ($urandom_range(0, 9) == 0) seq.insert($urandom_range(0, seq.size()), noise_char());
    seq.push_back(CH_END);
    foreach (seq[i]) send_char(seq[i]);
  endtask

  // sender: reset, directed words, random stream, drain
  initial begin
    rst_ni            <= 1'b0;
    char_if.valid     <= 1'b0;
    char_if.char_code <= '0;
    sender_calm = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty entry and sign-only entry
    send_char(CH_END);
    send_char(CH_MINUS);
    send_char(CH_END);
    // late minus, fills the window to three
    send_char(CH_ZERO + 8'd7);
    send_char(CH_MINUS);
    send_char(CH_ZERO + 8'd2);
    send_char(CH_END);
    // ignored characters at the field extremes
    send_char(8'h00);
    send_char(8'hFF);
    // clear, then an entry far past the positive limit
    send_char(CH_CLEAR);
    send_number(64'd99999999999, 1'b0);

    while (chars_taken < CHAR_TARGET) begin
      case ($urandom_range(0, 99)) inside
        [0:84]:  send_entry();
        [85:91]: send_char(CH_CLEAR);
        default: send_char(noise_char());
      endcase
    end
    char_if.valid <= 1'b0;

    while (tracker.pending_windows.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_windows.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: check accepted words, stall at random, one long hold-off
  initial begin
    int stall_left;
    bit calm;
    bit held_off;
    stall_left = 0;
    calm       = 1'b0;
    held_off   = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        tracker.check_result(res_if.entered_value, res_if.window_sum,
                             res_if.window_median, res_if.values_held);
      end
      if (!held_off && chars_taken >= 600) begin
        stall_left = 400;
        held_off   = 1'b1;
      end
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 2) == 0) stall_left = gap_len();
      end
    end
  end

endmodule
